// File: hw/rtl/tcprx_pkg.sv
`timescale 1ns / 1ps

package tcprx_pkg;

  localparam int unsigned HdrLen     = 20;
  localparam int unsigned HdrIdxW    = 5;
  // byte pair holding the checksum field (bytes 16 and 17)
  localparam logic [14:0] ChkPairIdx = 15'd8;
  localparam logic [3:0]  MinOffset  = 4'd5;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusShort    = 2'd1,
    StatusMismatch = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol;
    logic [15:0] segment_length;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [3:0]  data_offset;
    logic [7:0]  flag_bits;
    logic [15:0] window_size;
    logic [15:0] urgent_pointer;
    logic [15:0] received_checksum;
    logic [15:0] computed_checksum;
    logic [5:0]  options_length;
  } out_beat_t;

  // end-around carry of a 17-bit sum; one pass always clears the carry
  function automatic logic [15:0] fold17(logic [16:0] v);
    return v[15:0] + 16'(v[16]);
  endfunction

  function automatic logic [15:0] pseudo_sum(logic [31:0] sa, logic [31:0] da,
                                             logic [7:0] proto, logic [15:0] len);
    logic [18:0] s;
    logic [16:0] t;
    s = 19'(sa[31:16]) + 19'(sa[15:0]) + 19'(da[31:16]) + 19'(da[15:0])
      + 19'(proto) + 19'(len);
    t = 17'(s[15:0]) + 17'(s[18:16]);
    return fold17(t);
  endfunction

endpackage

// File: hw/rtl/tcprx_core.sv
`timescale 1ns / 1ps

module tcprx_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tcprx_pkg::in_beat_t  beat_i,
  input  logic [15:0]          pseudo_i,
  output logic                 last_o,
  output tcprx_pkg::out_beat_t res_o
);

  logic [15:0] count_q, count_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [7:0]  hdr_q [tcprx_pkg::HdrLen];
  logic [7:0]  hdr   [tcprx_pkg::HdrLen];

  logic [15:0] idx, cnt, sum_base, sum1, sum_fin, comp, rx;
  logic [3:0]  off;
  logic        odd, in_hdr;

  assign idx      = beat_i.first_byte ? 16'd0 : count_q;
  assign sum_base = beat_i.first_byte ? pseudo_i : sum_q;
  assign odd      = idx[0];
  assign cnt      = idx + 16'd1;
  assign in_hdr   = idx < 16'(tcprx_pkg::HdrLen);
  assign last_o   = beat_i.last_byte;

  always_comb begin
    sum1 = sum_base;
    if (odd && idx[15:1] != tcprx_pkg::ChkPairIdx) begin
      sum1 = tcprx_pkg::fold17(17'(sum_base) + 17'({hold_q, beat_i.data_byte}));
    end
    // odd-length segment: trailing byte padded with a zero low byte
    sum_fin = sum1;
    if (!odd && idx[15:1] != tcprx_pkg::ChkPairIdx) begin
      sum_fin = tcprx_pkg::fold17(17'(sum1) + 17'({beat_i.data_byte, 8'h00}));
    end
    comp = ~sum_fin;
  end

  // header view including the byte going by now
  always_comb begin
    for (int k = 0; k < tcprx_pkg::HdrLen; k++) begin
      hdr[k] = (in_hdr && idx[tcprx_pkg::HdrIdxW-1:0] == tcprx_pkg::HdrIdxW'(k))
               ? beat_i.data_byte : hdr_q[k];
    end
  end

  assign off = hdr[12][7:4];
  assign rx  = {hdr[16], hdr[17]};

  always_comb begin
    res_o = '0;
    res_o.computed_checksum = comp;
    if (cnt < 16'(tcprx_pkg::HdrLen)) begin
      res_o.status = tcprx_pkg::StatusShort;
    end else begin
      res_o.source_port       = {hdr[0], hdr[1]};
      res_o.dest_port         = {hdr[2], hdr[3]};
      res_o.sequence_number   = {hdr[4], hdr[5], hdr[6], hdr[7]};
      res_o.ack_number        = {hdr[8], hdr[9], hdr[10], hdr[11]};
      res_o.data_offset       = off;
      res_o.flag_bits         = hdr[13];
      res_o.window_size       = {hdr[14], hdr[15]};
      res_o.urgent_pointer    = {hdr[18], hdr[19]};
      res_o.received_checksum = rx;
      res_o.options_length    = (off > tcprx_pkg::MinOffset)
                                ? ({off, 2'b00} - 6'(tcprx_pkg::HdrLen)) : 6'd0;
      if (16'({off, 2'b00}) > cnt) begin
        res_o.status = tcprx_pkg::StatusShort;
      end else if (rx != comp) begin
        res_o.status = tcprx_pkg::StatusMismatch;
      end else begin
        res_o.status = tcprx_pkg::StatusOk;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    hold_d  = hold_q;
    if (en_i) begin
      if (beat_i.last_byte) begin
        count_d = '0;
        sum_d   = '0;
        hold_d  = '0;
      end else begin
        count_d = cnt;
        sum_d   = sum1;
        hold_d  = odd ? hold_q : beat_i.data_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_hdr) begin
      hdr_q[idx[tcprx_pkg::HdrIdxW-1:0]] <= beat_i.data_byte;
    end
  end

endmodule

// File: hw/rtl/tcp_rx_parse_checksum_verify.sv
`timescale 1ns / 1ps

// Channel   Valid        Ready        Payload
// in        in_valid_i   in_ready_o   in_data_i  (one segment byte per beat)
// out       out_valid_o  out_ready_i  out_data_o (one result per last byte)
//
// One byte per cycle sustained while no result waits on out_ready_i; out_valid_o
// rises once the last byte has gone through the input register, then the
// parse/checksum logic into the result register. Reset clears the byte count,
// running sum and valid flags. A result held by out_ready_i low stalls the
// input register, and in_ready_o drops once that register is full.

module tcp_rx_parse_checksum_verify (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcprx_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tcprx_pkg::out_beat_t out_data_o
);

  logic                 s1_valid_q, s1_valid_d;
  tcprx_pkg::in_beat_t  s1_beat_q;
  logic [15:0]          pseudo_q;
  logic                 out_valid_q, out_valid_d;
  tcprx_pkg::out_beat_t out_q;
  tcprx_pkg::out_beat_t res;
  logic                 res_last;
  logic                 s2_ready, fire1, accept;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign fire1      = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign accept     = in_valid_i && in_ready_o;

  tcprx_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire1),
    .beat_i  (s1_beat_q),
    .pseudo_i(pseudo_q),
    .last_o  (res_last),
    .res_o   (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire1) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire1) begin
      out_valid_d = res_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_beat_q <= in_data_i;
      pseudo_q  <= tcprx_pkg::pseudo_sum(in_data_i.source_address,
                                         in_data_i.dest_address,
                                         in_data_i.protocol,
                                         in_data_i.segment_length);
    end
    if (fire1 && res_last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: dv/tb_tcp_rx_parse_checksum_verify.sv
`timescale 1ns / 1ps

module tb_tcp_rx_parse_checksum_verify;

  localparam int unsigned CycleLimit = 500_000;

  typedef logic [7:0] byte_q_t[$];

  // Tracks byte count, ones'-complement sum and header bytes of the segment in
  // flight; queues one expected report per last byte.
  class segment_scoreboard;
    logic [15:0] byte_count;
    logic [15:0] word_sum;
    logic [7:0]  high_hold;
    logic [7:0]  hdr[tcprx_pkg::HdrLen];
    tcprx_pkg::out_beat_t expected_reports[$];
    int          errors, n_ok, n_short, n_mismatch;

    function new();
      byte_count = '0;
      word_sum   = '0;
      high_hold  = '0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    static function logic [15:0] fold(logic [31:0] t);
      while (t[31:16] != 16'h0) t = 32'(t[15:0]) + 32'(t[31:16]);
      return t[15:0];
    endfunction

    static function logic [15:0] add_word(logic [15:0] s, logic [15:0] w);
      return fold(32'(s) + 32'(w));
    endfunction

    static function logic [15:0] pseudo_seed(logic [31:0] sa, logic [31:0] da,
                                             logic [7:0] proto, logic [15:0] len);
      return fold(32'(sa[31:16]) + 32'(sa[15:0]) + 32'(da[31:16]) + 32'(da[15:0])
                  + 32'(proto) + 32'(len));
    endfunction

    function void take_byte(tcprx_pkg::in_beat_t b);
      logic [15:0] idx, cnt;
      logic [3:0]  off;
      tcprx_pkg::out_beat_t r;
      if (b.first_byte) begin
        word_sum  = pseudo_seed(b.source_address, b.dest_address, b.protocol,
                                b.segment_length);
        high_hold = '0;
        idx       = '0;
      end else begin
        idx = byte_count;
      end
      if (idx < tcprx_pkg::HdrLen) hdr[idx] = b.data_byte;
      if (!idx[0]) begin
        high_hold = b.data_byte;
      end else if (idx[15:1] != tcprx_pkg::ChkPairIdx) begin
        word_sum = add_word(word_sum, {high_hold, b.data_byte});
      end
      cnt = idx + 16'd1;
      if (!b.last_byte) begin
        byte_count = cnt;
        return;
      end
      // odd trailing byte goes in as the high half of a zero-padded word
      if (!idx[0] && idx[15:1] != tcprx_pkg::ChkPairIdx) begin
        word_sum = add_word(word_sum, {b.data_byte, 8'h00});
      end
      r = '0;
      r.computed_checksum = ~word_sum;
      if (cnt < tcprx_pkg::HdrLen) begin
        r.status = tcprx_pkg::StatusShort;
      end else begin
        off = hdr[12][7:4];
        r.source_port       = {hdr[0], hdr[1]};
        r.dest_port         = {hdr[2], hdr[3]};
        r.sequence_number   = {hdr[4], hdr[5], hdr[6], hdr[7]};
        r.ack_number        = {hdr[8], hdr[9], hdr[10], hdr[11]};
        r.data_offset       = off;
        r.flag_bits         = hdr[13];
        r.window_size       = {hdr[14], hdr[15]};
        r.received_checksum = {hdr[16], hdr[17]};
        r.urgent_pointer    = {hdr[18], hdr[19]};
        r.options_length    = (off > tcprx_pkg::MinOffset)
                              ? 6'(32'(off) * 4 - tcprx_pkg::HdrLen) : '0;
        if (32'(off) * 4 > 32'(cnt)) begin
          r.status = tcprx_pkg::StatusShort;
        end else if (r.received_checksum != r.computed_checksum) begin
          r.status = tcprx_pkg::StatusMismatch;
        end else begin
          r.status = tcprx_pkg::StatusOk;
        end
      end
      case (r.status)
        tcprx_pkg::StatusOk:    n_ok++;
        tcprx_pkg::StatusShort: n_short++;
        default:                n_mismatch++;
      endcase
      expected_reports.push_back(r);
      byte_count = '0;
      word_sum   = '0;
      high_hold  = '0;
    endfunction

    function void diff(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_report(tcprx_pkg::out_beat_t act);
      tcprx_pkg::out_beat_t e;
      if (expected_reports.size() == 0) begin
        $error("result beat with none pending: status %0d computed_checksum %h",
               act.status, act.computed_checksum);
        errors++;
        return;
      end
      e = expected_reports.pop_front();
      diff("status", e.status, act.status);
      diff("source_port", e.source_port, act.source_port);
      diff("dest_port", e.dest_port, act.dest_port);
      diff("sequence_number", e.sequence_number, act.sequence_number);
      diff("ack_number", e.ack_number, act.ack_number);
      diff("data_offset", e.data_offset, act.data_offset);
      diff("flag_bits", e.flag_bits, act.flag_bits);
      diff("window_size", e.window_size, act.window_size);
      diff("urgent_pointer", e.urgent_pointer, act.urgent_pointer);
      diff("received_checksum", e.received_checksum, act.received_checksum);
      diff("computed_checksum", e.computed_checksum, act.computed_checksum);
      diff("options_length", e.options_length, act.options_length);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  tcprx_pkg::in_beat_t  in_beat = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  tcprx_pkg::out_beat_t out_data_o;

  segment_scoreboard sb = new();
  bit idle_on;
  int stall_left;
  int bytes_sent;
  int segs;

  tcp_rx_parse_checksum_verify uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles", CycleLimit);
    $display("Some tests failed");
    $finish;
  end

  // result side: check accepted beats, stall in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) sb.check_report(out_data_o);
      if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic drive_byte(input logic [7:0] d, input logic first, input logic last,
                            input logic [31:0] sa, input logic [31:0] da,
                            input logic [7:0] proto, input logic [15:0] len);
    tcprx_pkg::in_beat_t b;
    b.data_byte      = d;
    b.first_byte     = first;
    b.last_byte      = last;
    b.source_address = sa;
    b.dest_address   = da;
    b.protocol       = proto;
    b.segment_length = len;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  // pseudo-header fields on later bytes must be ignored, so they get noise
  task automatic send_segment(input byte_q_t seg, input logic [31:0] sa,
                              input logic [31:0] da, input logic [7:0] proto,
                              input logic [15:0] len);
    int i;
    drive_byte(seg[0], 1'b1, seg.size() == 1, sa, da, proto, len);
    for (i = 1; i < seg.size(); i++) begin
      drive_byte(seg[i], 1'b0, i == seg.size() - 1, $urandom, $urandom, 8'($urandom),
                 16'($urandom));
    end
    segs++;
  endtask

  // header with the given offset nibble plus body bytes; optionally a valid checksum
  function automatic byte_q_t build_segment(int off, int body, bit fix,
                                            logic [31:0] sa, logic [31:0] da,
                                            logic [7:0] proto, logic [15:0] len);
    byte_q_t     seg;
    logic [15:0] s;
    logic [7:0]  lo;
    int          i;
    for (i = 0; i < int'(tcprx_pkg::HdrLen) + body; i++) begin
      if (i == 12) seg.push_back({4'(off), 4'($urandom)});
      else seg.push_back(8'($urandom));
    end
    if (fix) begin
      s = segment_scoreboard::pseudo_seed(sa, da, proto, len);
      for (i = 0; i < seg.size(); i += 2) begin
        lo = (i + 1 < seg.size()) ? seg[i + 1] : 8'h00;
        if (i != 16) s = segment_scoreboard::add_word(s, {seg[i], lo});
      end
      seg[16] = ~s[15:8];
      seg[17] = ~s[7:0];
    end
    return seg;
  endfunction

  task automatic random_segment();
    byte_q_t     seg;
    logic [31:0] sa, da;
    logic [7:0]  proto;
    logic [15:0] len;
    int          kind, off, body, n, i;
    sa    = $urandom;
    da    = $urandom;
    proto = 8'($urandom);
    len   = 16'($urandom);
    kind  = $urandom_range(0, 99);
    if (kind < 12) begin
      // arbitrary framing: stray first/last flags, bytes with no first
      n = $urandom_range(1, 24);
      for (i = 0; i < n; i++) begin
        drive_byte(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                   $urandom, $urandom, 8'($urandom), 16'($urandom));
      end
      segs++;
    end else if (kind < 24) begin
      n = $urandom_range(1, 19);
      for (i = 0; i < n; i++) seg.push_back(8'($urandom));
      send_segment(seg, sa, da, proto, len);
    end else begin
      off  = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      body = (off > 5) ? off * 4 - 20 : 0;
      if (off > 5 && $urandom_range(0, 6) == 0) begin
        body = $urandom_range(0, body - 1);
      end else begin
        body += $urandom_range(0, 24);
      end
      seg = build_segment(off, body, $urandom_range(0, 9) < 6, sa, da, proto, len);
      send_segment(seg, sa, da, proto, len);
    end
  endtask

  initial begin
    byte_q_t seg;
    int      k;
    idle_on = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes with no first flag right after reset, odd count, too short
    drive_byte(8'hFF, 1'b0, 1'b0, '1, '1, '1, '1);
    drive_byte(8'h00, 1'b0, 1'b0, '0, '0, '0, '0);
    drive_byte(8'hFF, 1'b0, 1'b1, '1, '1, '1, '1);
    // single byte segment, zero pseudo-header
    drive_byte(8'h00, 1'b1, 1'b1, '0, '0, '0, '0);
    // bare 20-byte header, all-ones pseudo-header, matching checksum
    seg = build_segment(5, 0, 1'b1, '1, '1, '1, '1);
    send_segment(seg, '1, '1, '1, '1);

    while (bytes_sent < 1000) begin
      idle_on = ($urandom_range(0, 3) != 0);
      random_segment();
    end
    idle_on = 1'b0;
    for (k = 0; k < 10; k++) random_segment();
    in_valid <= 1'b0;

    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d segments; %0d reports: %0d ok, %0d short, %0d mismatch.",
             bytes_sent, segs, sb.n_ok + sb.n_short + sb.n_mismatch, sb.n_ok, sb.n_short,
             sb.n_mismatch);
    $display("Included stray framing flags, short headers, odd lengths and random stalls.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
